### design/cfr_pkg.sv
`timescale 1ns / 1ps

package cfr_pkg;

  // Frame limits and derived counter widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIMW_W     = COL_W + 1;
  localparam int DIMH_W     = ROW_W + 1;
  localparam int MIN_SIZE   = 3;

  // Port widths
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int MODE_W     = 3;
  localparam int STRENGTH_W = 7;

  // Kernel constants
  localparam int PIX_MAX     = 255;
  localparam int BOX_DIV     = 9;
  localparam int GAUSS_SHIFT = 4;
  localparam int SHARP_DIV   = 10;
  localparam int LAP_OFFSET  = 128;
  localparam int SHARP_SAT   = (PIX_MAX + 1) * SHARP_DIV;

  // Rounded-up reciprocals, exact for the 12-bit dividends used here
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP9      = ((1 << RECIP_SHIFT) + BOX_DIV - 1) / BOX_DIV;
  localparam int RECIP10     = ((1 << RECIP_SHIFT) + SHARP_DIV - 1) / SHARP_DIV;

  // Result slots of one pixel, in delivery order
  localparam int RES_CENTER = 0;
  localparam int RES_RIGHT  = 1;
  localparam int RES_BOTTOM = 2;
  localparam int NUM_RES    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE = 2'd0,
    CFG_SHARP       = 2'd1,
    CFG_WIDTH       = 2'd2,
    CFG_HEIGHT      = 2'd3
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDENT = 3'd0,
    MODE_AVG   = 3'd1,
    MODE_GAUSS = 3'd2,
    MODE_SHARP = 3'd3,
    MODE_LAPL  = 3'd4
  } filt_mode_e;

  typedef enum logic [1:0] {
    RK_PASS  = 2'd0,
    RK_DIV9  = 2'd1,
    RK_DIV10 = 2'd2,
    RK_SAT   = 2'd3
  } res_kind_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t upper;
    rgb_t middle;
  } line_ent_t;

  typedef rgb_t [8:0] win_t;
  typedef logic [8:0][PIX_W-1:0] tap9_t;

  typedef struct packed {
    logic center;
    logic interior;
    logic right;
    logic bottom;
  } res_flags_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    res_flags_t       flags;
  } pix_tag_t;

  function automatic int clamp_dim(int v, int hi);
    int r;
    r = v;
    if (v < MIN_SIZE) r = MIN_SIZE;
    else if (v > hi) r = hi;
    return r;
  endfunction

  localparam int WIDTH_RST  = clamp_dim(640, MAX_WIDTH);
  localparam int HEIGHT_RST = clamp_dim(480, MAX_HEIGHT);

endpackage

### design/cfr_line_buf.sv
`timescale 1ns / 1ps

module cfr_line_buf
  import cfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  output line_ent_t        rd_data_o,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  line_ent_t        wr_data_i
);

  line_ent_t line_mem_q [MAX_WIDTH];
  line_ent_t rd_data_q;

  // Read both line stores of one column, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= line_mem_q[rd_addr_i];
    end
  end

  // Write back the shifted column
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/cfr_window.sv
`timescale 1ns / 1ps

module cfr_window
  import cfr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  rgb_t up_i,
  input  rgb_t mid_i,
  input  rgb_t px_i,
  output win_t win_o
);

  win_t win_q;

  // Shift the 3x3 window left and insert the new column on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]     <= win_q[r*3 + 1];
        win_q[r*3 + 1] <= win_q[r*3 + 2];
      end
      win_q[2] <= up_i;
      win_q[5] <= mid_i;
      win_q[8] <= px_i;
    end
  end

  assign win_o = win_q;

endmodule

### design/cfr_chan_filter.sv
`timescale 1ns / 1ps

module cfr_chan_filter
  import cfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  en_i,
  input  filt_mode_e            mode_i,
  input  logic [STRENGTH_W-1:0] strength_i,
  input  tap9_t                 taps_i,
  output logic [PIX_W-1:0]      res_o
);

  localparam int SUM_W    = 12;
  localparam int OTHERS_W = 11;
  localparam int NBR_W    = 10;
  localparam int WEIGHT_W = 11;
  localparam int CPROD_W  = WEIGHT_W + PIX_W;
  localparam int OPROD_W  = STRENGTH_W + OTHERS_W;
  localparam int DIFF_W   = CPROD_W + 1;
  localparam int LAP_W    = 12;
  localparam int X_W      = 12;
  localparam int RECIP_W  = 13;
  localparam int PROD_W   = X_W + RECIP_W;

  localparam logic signed [DIFF_W-1:0] SharpLim = DIFF_W'(SHARP_SAT);

  // First stage: sums and products of the taps
  logic [OTHERS_W-1:0] others;
  logic [NBR_W-1:0]    nbr4;
  logic [WEIGHT_W-1:0] weight;
  logic [SUM_W-1:0]    sum9_d, sum9_q;
  logic [SUM_W-1:0]    gsum_d, gsum_q;
  logic [CPROD_W-1:0]  cprod_d, cprod_q;
  logic [OPROD_W-1:0]  oprod_d, oprod_q;
  logic [LAP_W-1:0]    lap_d, lap_q;
  logic [PIX_W-1:0]    ctr_q;

  always_comb begin
    others = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) others = others + OTHERS_W'(taps_i[i]);
    end
    nbr4 = NBR_W'(taps_i[1]) + NBR_W'(taps_i[3]) + NBR_W'(taps_i[5]) + NBR_W'(taps_i[7]);
    sum9_d = SUM_W'(others) + SUM_W'(taps_i[4]);
    gsum_d = SUM_W'(taps_i[0]) + SUM_W'(taps_i[2]) + SUM_W'(taps_i[6]) + SUM_W'(taps_i[8])
           + (SUM_W'(nbr4) << 1) + (SUM_W'(taps_i[4]) << 2);
    lap_d  = (LAP_W'(taps_i[4]) << 2) + LAP_W'(LAP_OFFSET) - LAP_W'(nbr4);
    weight = (WEIGHT_W'(strength_i) << 3) + WEIGHT_W'(SHARP_DIV);
    cprod_d = CPROD_W'(weight) * CPROD_W'(taps_i[4]);
    oprod_d = OPROD_W'(strength_i) * OPROD_W'(others);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum9_q  <= sum9_d;
      gsum_q  <= gsum_d;
      cprod_q <= cprod_d;
      oprod_q <= oprod_d;
      lap_q   <= lap_d;
      ctr_q   <= taps_i[4];
    end
  end

  // Second stage: pick the mode, clip negatives and flag saturation
  logic signed [DIFF_W-1:0] diff;
  logic [X_W-1:0]           x_d, x_q;
  res_kind_e                kind_d, kind_q;

  always_comb begin
    diff   = $signed({1'b0, cprod_q}) - $signed({2'b00, oprod_q});
    x_d    = '0;
    kind_d = RK_PASS;
    case (mode_i)
      MODE_IDENT: x_d = X_W'(ctr_q);
      MODE_AVG: begin
        x_d    = X_W'(sum9_q);
        kind_d = RK_DIV9;
      end
      MODE_GAUSS: x_d = X_W'(gsum_q >> GAUSS_SHIFT);
      MODE_SHARP: begin
        if (diff <= 0) begin
          x_d = '0;
        end else if (diff >= SharpLim) begin
          kind_d = RK_SAT;
        end else begin
          x_d    = diff[X_W-1:0];
          kind_d = RK_DIV10;
        end
      end
      MODE_LAPL: begin
        if (lap_q[LAP_W-1]) begin
          x_d = '0;
        end else if (lap_q > LAP_W'(PIX_MAX)) begin
          kind_d = RK_SAT;
        end else begin
          x_d = X_W'(lap_q);
        end
      end
      default: x_d = X_W'(ctr_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      kind_q <= kind_d;
    end
  end

  // Third stage: divide by reciprocal multiply, pass through or saturate; result goes to the output register
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    recip = (kind_q == RK_DIV9) ? RECIP_W'(RECIP9) : RECIP_W'(RECIP10);
    prod  = PROD_W'(x_q) * PROD_W'(recip);
    case (kind_q)
      RK_PASS:  res_o = x_q[PIX_W-1:0];
      RK_DIV9:  res_o = prod[RECIP_SHIFT +: PIX_W];
      RK_DIV10: res_o = prod[RECIP_SHIFT +: PIX_W];
      RK_SAT:   res_o = PIX_W'(PIX_MAX);
      default:  res_o = x_q[PIX_W-1:0];
    endcase
  end

endmodule

### design/cfr_emit.sv
`timescale 1ns / 1ps

module cfr_emit
  import cfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_valid_i,
  input  pix_tag_t           load_tag_i,
  input  rgb_t               load_rgb_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PIX_W-1:0]   out_red_o,
  output logic [PIX_W-1:0]   out_green_o,
  output logic [PIX_W-1:0]   out_blue_o,
  output logic [COORD_W-1:0] out_col_o,
  output logic [COORD_W-1:0] out_row_o,
  output logic               last_of_run_o
);

  logic [NUM_RES-1:0] pend_d, pend_q;
  logic [NUM_RES-1:0] cur;
  logic               last;
  pix_tag_t           tag_q;
  rgb_t               rgb_q;
  rgb_t               rgb_sel;
  logic [COL_W-1:0]   col_sel;
  logic [ROW_W-1:0]   row_sel;

  // Select the oldest pending result of the held pixel
  always_comb begin
    cur    = pend_q & (~pend_q + NUM_RES'(1));
    last   = (pend_q & ~cur) == '0;
    take_o = (pend_q == '0) || (out_ready_i && last);

    rgb_sel = '0;
    col_sel = tag_q.col;
    row_sel = tag_q.row;
    if (cur[RES_CENTER]) begin
      rgb_sel = tag_q.flags.interior ? rgb_q : '0;
      col_sel = tag_q.col - COL_W'(1);
      row_sel = tag_q.row - ROW_W'(1);
    end else if (cur[RES_RIGHT]) begin
      row_sel = tag_q.row - ROW_W'(1);
    end

    out_valid_o   = pend_q != '0;
    out_red_o     = rgb_sel.red;
    out_green_o   = rgb_sel.green;
    out_blue_o    = rgb_sel.blue;
    out_col_o     = COORD_W'(col_sel);
    out_row_o     = COORD_W'(row_sel);
    last_of_run_o = last;
  end

  // Load a new pixel or drop the result just taken
  always_comb begin
    pend_d = pend_q;
    if (take_o) begin
      pend_d = '0;
      if (load_valid_i) begin
        pend_d[RES_CENTER] = load_tag_i.flags.center;
        pend_d[RES_RIGHT]  = load_tag_i.flags.right;
        pend_d[RES_BOTTOM] = load_tag_i.flags.bottom;
      end
    end else if (out_valid_o && out_ready_i) begin
      pend_d = pend_q & ~cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      tag_q <= load_tag_i;
      rgb_q <= load_rgb_i;
    end
  end

endmodule

### design/conv3x3_rgb_filter_unit.sv
`timescale 1ns / 1ps

// Channel   | Signals                                   | Transfer
// ----------+-------------------------------------------+----------------------------
// pixel in  | in_valid_i/in_ready_o, red/green/blue_i   | one raster pixel
// result    | out_valid_o/out_ready_i, out_*_o, last_*  | one pixel result, 0..3 per
//           |                                           | input pixel
// config    | cfg_we_i, cfg_index_i, cfg_data_i         | one register write
//
// One pixel is taken per cycle while the result port is not stalled; a pixel that
// causes two or three results holds the input until its last result is taken, as
// the result port moves one per cycle. After it is taken, a pixel passes the line
// store read, window, two filter stages and output register, in that order, before
// its first result can be taken.
// Reset clears counters, configuration registers, window and pipeline valids; line
// stores are not cleared. An output stall freezes the whole pipeline.

module conv3x3_rgb_filter_unit
  import cfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      red_i,
  input  logic [PIX_W-1:0]      green_i,
  input  logic [PIX_W-1:0]      blue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      out_red_o,
  output logic [PIX_W-1:0]      out_green_o,
  output logic [PIX_W-1:0]      out_blue_o,
  output logic [COORD_W-1:0]    out_col_o,
  output logic [COORD_W-1:0]    out_row_o,
  output logic                  last_of_run_o
);

  logic en;
  logic accept;

  // Configuration registers and raster counters
  filt_mode_e            mode_q;
  logic [STRENGTH_W-1:0] strength_q;
  logic [DIMW_W-1:0]     width_q;
  logic [DIMH_W-1:0]     height_q;
  logic [COL_W-1:0]      col_d, col_q;
  logic [ROW_W-1:0]      row_d, row_q;
  logic                  col_end;
  logic                  row_end;
  pix_tag_t              tag0;

  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  always_comb begin
    col_end = {1'b0, col_q} == (width_q - DIMW_W'(1));
    row_end = {1'b0, row_q} == (height_q - DIMH_W'(1));

    tag0.col            = col_q;
    tag0.row            = row_q;
    tag0.flags.center   = (col_q != '0) && (row_q != '0);
    tag0.flags.interior = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
    tag0.flags.right    = col_end && (row_q != '0);
    tag0.flags.bottom   = row_end;

    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDENT;
      strength_q <= '0;
      width_q    <= DIMW_W'(WIDTH_RST);
      height_q   <= DIMH_W'(HEIGHT_RST);
      col_q      <= '0;
      row_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FILTER_MODE: mode_q <= filt_mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_SHARP:       strength_q <= cfg_data_i[STRENGTH_W-1:0];
        CFG_WIDTH: begin
          width_q <= DIMW_W'(clamp_dim(int'(cfg_data_i), MAX_WIDTH));
          col_q   <= '0;
          row_q   <= '0;
        end
        CFG_HEIGHT: begin
          height_q <= DIMH_W'(clamp_dim(int'(cfg_data_i), MAX_HEIGHT));
          col_q    <= '0;
          row_q    <= '0;
        end
        default: mode_q <= mode_q;
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: pixel waits for its line store column
  logic      v1_q;
  pix_tag_t  tag1_q;
  rgb_t      px1_q;
  line_ent_t rd_data;
  line_ent_t wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag1_q <= tag0;
      px1_q  <= '{red: red_i, green: green_i, blue: blue_i};
    end
  end

  assign wr_data = '{upper: rd_data.middle, middle: px1_q};

  cfr_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (en && v1_q),
    .wr_addr_i (tag1_q.col),
    .wr_data_i (wr_data)
  );

  // Stage 2: window holds the 3x3 block whose lower right corner is the pixel
  logic     v2_q;
  pix_tag_t tag2_q;
  win_t     win;
  tap9_t    red_taps, green_taps, blue_taps;

  cfr_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (en && v1_q),
    .up_i    (rd_data.upper),
    .mid_i   (rd_data.middle),
    .px_i    (px1_q),
    .win_o   (win)
  );

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      red_taps[i]   = win[i].red;
      green_taps[i] = win[i].green;
      blue_taps[i]  = win[i].blue;
    end
  end

  // Stages 3 and 4: filter arithmetic, tags follow alongside
  logic     v3_q, v4_q;
  pix_tag_t tag3_q, tag4_q;
  rgb_t     filt_rgb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
    end
  end

  cfr_chan_filter u_filt_red (
    .clk_i      (clk_i),
    .en_i       (en),
    .mode_i     (mode_q),
    .strength_i (strength_q),
    .taps_i     (red_taps),
    .res_o      (filt_rgb.red)
  );

  cfr_chan_filter u_filt_green (
    .clk_i      (clk_i),
    .en_i       (en),
    .mode_i     (mode_q),
    .strength_i (strength_q),
    .taps_i     (green_taps),
    .res_o      (filt_rgb.green)
  );

  cfr_chan_filter u_filt_blue (
    .clk_i      (clk_i),
    .en_i       (en),
    .mode_i     (mode_q),
    .strength_i (strength_q),
    .taps_i     (blue_taps),
    .res_o      (filt_rgb.blue)
  );

  // Output register hands out up to three results per pixel
  cfr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_valid_i  (v4_q),
    .load_tag_i    (tag4_q),
    .load_rgb_i    (filt_rgb),
    .take_o        (en),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### design/cfr_checker.sv
`timescale 1ns / 1ps

module cfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_red_o,
  input logic [7:0]  out_green_o,
  input logic [7:0]  out_blue_o,
  input logic [9:0]  out_col_o,
  input logic [9:0]  out_row_o,
  input logic        last_of_run_o
);

  // Hold a stalled result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_col_o) && $stable(out_row_o)
      && $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o)
      && $stable(last_of_run_o))
    else $error("stalled result changed");

  // A run that is not finished continues in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("result run broken off");

  // Border results carry zero color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_col_o == 10'd0 || out_row_o == 10'd0)
      |-> out_red_o == 8'd0 && out_green_o == 8'd0 && out_blue_o == 8'd0)
    else $error("border result not zero");

  // No pixel is taken while the output holds more of the same run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> !in_ready_o)
    else $error("input taken during a run");

endmodule

bind conv3x3_rgb_filter_unit cfr_checker u_cfr_checker (.*);
